// ===== hw/rtl/soft_dab_pixel_shader_unit_defines.svh =====
// Assertion macros shared by the soft dab shader checker.
`ifndef SOFT_DAB_PIXEL_SHADER_UNIT_DEFINES_SVH
`define SOFT_DAB_PIXEL_SHADER_UNIT_DEFINES_SVH

// Checked only outside reset.
`define SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/soft_dab_pkg.sv =====
// Types, constants and helpers for the soft dab pixel shader.
`timescale 1ns / 1ps
package soft_dab_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DAB_ALPHA   = 2'd0,
    REG_HARDNESS    = 2'd1,
    REG_BRUSH_COLOR = 2'd2,
    REG_ADDITIVE    = 2'd3
  } cfg_reg_t;

  // Pipeline stage map
  localparam int ST_A      = 0;
  localparam int ST_B      = 1;
  localparam int ST_SQ     = 2;
  localparam int SQ_STAGES = 6;
  localparam int SQ_PER    = 3;
  localparam int SQ_BITS   = 17;
  localparam int ST_DV     = ST_SQ + SQ_STAGES;
  localparam int DV_STAGES = 5;
  localparam int DV_PER    = 4;
  localparam int ST_M0     = ST_DV + DV_STAGES;
  localparam int ST_M1     = ST_M0 + 1;
  localparam int ST_B0     = ST_M1 + 1;
  localparam int ST_OUT    = ST_B0 + 1;
  localparam int NST       = ST_OUT + 1;

  localparam logic [6:0]  HARD_MAX     = 7'd100;
  localparam logic [16:0] FALL_ONE     = 17'h10000;
  // floor(n / 100) = (n * IQ_RECIP) >> 30 for n < 2^23
  localparam logic [23:0] IQ_RECIP     = 24'd10737419;
  // floor(n / 255) = (n * DIV255_RECIP) >> 25 for n < 2^17
  localparam logic [17:0] DIV255_RECIP = 18'd131587;

  typedef struct packed {
    logic [17:0] d2;
    logic [7:0]  r;
    logic [14:0] hp;
    logic        outside;
    logic [15:0] iq;
    logic [15:0] den;
    logic [19:0] srem;
    logic [16:0] root;
    logic        full;
    logic [15:0] drem;
    logic [16:0] q;
    logic [33:0] fsq;
    logic [7:0]  a;
    logic        we;
    logic [15:0] nr;
    logic [15:0] ng;
    logic [15:0] nb;
    logic [16:0] na;
    logic [31:0] dst;
  } pix_t;

  // Divide by 255 through a reciprocal multiply; valid for n below 65280, where the quotient fits in 8 bits
  function automatic logic [7:0] div255(input logic [16:0] n);
    logic [34:0] p;
    p = {18'd0, n} * {17'd0, DIV255_RECIP};
    return p[32:25];
  endfunction

endpackage

// ===== hw/rtl/soft_dab_pixel_shader_unit.sv =====
// Each pixel passes registered stages A, B, SQ, DV, M0, M1, B0 and OUT; it waits longer only while out_stall holds.
// Throughput: one pixel per cycle while out_stall is low; pipeline bubbles collapse under a stall.
// Depth is set by the 17-bit digit-by-digit square root (6 stages) and the
// 17-bit restoring falloff divider (5 stages).
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
`timescale 1ns / 1ps
module soft_dab_pixel_shader_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [8:0]                   in_offset_x,
  input  logic signed [8:0]                   in_offset_y,
  input  logic [7:0]                          in_dab_radius,
  input  logic [31:0]                         in_dst_pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_write_enable,
  output logic [7:0]                          out_coverage,
  output logic [31:0]                         out_out_pixel,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [soft_dab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [soft_dab_pkg::CFG_DATA_W-1:0] cfg_data
);
  import soft_dab_pkg::*;

  logic [7:0]  dab_alpha_r;
  logic [6:0]  hardness_r;
  logic [23:0] brush_color_r;
  logic        additive_r;

  pix_t        pipe_r [NST];
  pix_t        pipe_nxt [NST];
  logic [NST-1:0] valid_r;
  logic [NST-1:0] en;
  logic        we_r, we_nxt;
  logic [7:0]  cov_r, cov_nxt;
  logic [31:0] pix_r, pix_nxt;

  // Configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dab_alpha_r   <= 8'd255;
      hardness_r    <= 7'd35;
      brush_color_r <= 24'd0;
      additive_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DAB_ALPHA:   dab_alpha_r   <= cfg_data[7:0];
        REG_HARDNESS:    hardness_r    <= cfg_data[6:0];
        REG_BRUSH_COLOR: brush_color_r <= cfg_data[23:0];
        REG_ADDITIVE:    additive_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[NST-1] = !valid_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end
  assign in_stall = !en[0];

  // Datapath for every stage
  always_comb begin
    logic signed [17:0] xx, yy;
    logic [7:0]  rc;
    logic [6:0]  hard;
    logic [46:0] iq_prod;
    logic [15:0] rr;
    logic [33:0] v;
    logic [19:0] t;
    logic [19:0] trial;
    logic [16:0] dt;
    logic [15:0] diff;
    logic        q16;
    logic [16:0] fall;
    logic [41:0] prod;
    logic [9:0]  av;
    int          k;
    int          pi;

    for (int i = 1; i < NST; i++) pipe_nxt[i] = pipe_r[i-1];
    pipe_nxt[ST_A] = '0;

    // A: squared distance, clamped radius, hardness times radius
    xx   = in_offset_x * in_offset_x;
    yy   = in_offset_y * in_offset_y;
    rc   = (in_dab_radius == 8'd0) ? 8'd1 : in_dab_radius;
    hard = (hardness_r > HARD_MAX) ? HARD_MAX : hardness_r;
    pipe_nxt[ST_A].d2  = $unsigned(xx) + $unsigned(yy);
    pipe_nxt[ST_A].r   = rc;
    pipe_nxt[ST_A].hp  = {8'd0, hard} * {7'd0, rc};
    pipe_nxt[ST_A].dst = in_dst_pixel;

    // B: rim test and inner radius (divide by 100 as reciprocal multiply)
    rr      = {8'd0, pipe_r[ST_A].r} * {8'd0, pipe_r[ST_A].r};
    iq_prod = {24'd0, pipe_r[ST_A].hp, 8'd0} * {23'd0, IQ_RECIP};
    pipe_nxt[ST_B].outside = pipe_r[ST_A].d2 > {2'd0, rr};
    pipe_nxt[ST_B].iq      = iq_prod[45:30];

    // SQ: square root of d2 * 2^16, three result bits per stage, two in the last
    for (int s = 0; s < SQ_STAGES; s++) begin
      if (s == 0) begin
        pipe_nxt[ST_SQ].den = {pipe_r[ST_B].r, 8'd0} - pipe_r[ST_B].iq;
      end
      v = {pipe_r[ST_SQ+s-1].d2, 16'd0};
      for (int j = 0; j < SQ_PER; j++) begin
        k  = s * SQ_PER + j;
        pi = (k < SQ_BITS) ? SQ_BITS - 1 - k : 0;
        if (k < SQ_BITS) begin
          t     = {pipe_nxt[ST_SQ+s].srem[17:0], v[2*pi +: 2]};
          trial = {1'b0, pipe_nxt[ST_SQ+s].root, 2'b01};
          if (t >= trial) begin
            pipe_nxt[ST_SQ+s].srem = t - trial;
            pipe_nxt[ST_SQ+s].root = {pipe_nxt[ST_SQ+s].root[15:0], 1'b1};
          end else begin
            pipe_nxt[ST_SQ+s].srem = t;
            pipe_nxt[ST_SQ+s].root = {pipe_nxt[ST_SQ+s].root[15:0], 1'b0};
          end
        end
      end
    end

    // DV first stage: core test and top quotient bit
    pipe_nxt[ST_DV].full = (pipe_r[ST_DV-1].root <= {1'b0, pipe_r[ST_DV-1].iq}) ||
                           (pipe_r[ST_DV-1].den == 16'd0);
    diff = pipe_r[ST_DV-1].root[15:0] - pipe_r[ST_DV-1].iq;
    q16  = !pipe_nxt[ST_DV].full && (diff >= pipe_r[ST_DV-1].den);
    pipe_nxt[ST_DV].q = {16'd0, q16};
    if (pipe_nxt[ST_DV].full) pipe_nxt[ST_DV].drem = 16'd0;
    else if (q16)             pipe_nxt[ST_DV].drem = diff - pipe_r[ST_DV-1].den;
    else                      pipe_nxt[ST_DV].drem = diff;

    // DV remaining stages: four restoring steps each
    for (int s = 1; s < DV_STAGES; s++) begin
      for (int j = 0; j < DV_PER; j++) begin
        dt = {pipe_nxt[ST_DV+s].drem, 1'b0};
        if (dt >= {1'b0, pipe_nxt[ST_DV+s].den}) begin
          pipe_nxt[ST_DV+s].drem = 16'(dt - {1'b0, pipe_nxt[ST_DV+s].den});
          pipe_nxt[ST_DV+s].q    = {pipe_nxt[ST_DV+s].q[15:0], 1'b1};
        end else begin
          pipe_nxt[ST_DV+s].drem = dt[15:0];
          pipe_nxt[ST_DV+s].q    = {pipe_nxt[ST_DV+s].q[15:0], 1'b0};
        end
      end
    end

    // M0: falloff and its square
    fall = pipe_r[ST_M0-1].full ? FALL_ONE : FALL_ONE - pipe_r[ST_M0-1].q;
    pipe_nxt[ST_M0].fsq = {17'd0, fall} * {17'd0, fall};

    // M1: coverage, rounded half up
    prod = {34'd0, dab_alpha_r} * {8'd0, pipe_r[ST_M0].fsq} + 42'h0_8000_0000;
    av   = prod[41:32];
    pipe_nxt[ST_M1].a  = (av > 10'd255) ? 8'd255 : av[7:0];
    pipe_nxt[ST_M1].we = !pipe_r[ST_M0].outside && (pipe_nxt[ST_M1].a != 8'd0);

    // B0: blend products
    pipe_nxt[ST_B0].nr = {8'd0, brush_color_r[23:16]} * {8'd0, pipe_r[ST_M1].a};
    pipe_nxt[ST_B0].ng = {8'd0, brush_color_r[15:8]}  * {8'd0, pipe_r[ST_M1].a};
    pipe_nxt[ST_B0].nb = {8'd0, brush_color_r[7:0]}   * {8'd0, pipe_r[ST_M1].a};
    pipe_nxt[ST_B0].na = {9'd0, pipe_r[ST_M1].dst[31:24]} *
                         {9'd0, 8'd255 - pipe_r[ST_M1].a} + 17'd127;
  end

  // OUT: divide by 255, saturate, pack
  always_comb begin
    logic [8:0] cr, cg, cb;
    logic [7:0] oa;
    pix_t       p;
    p  = pipe_r[ST_B0];
    cr = {1'b0, p.dst[23:16]} + {1'b0, div255({1'b0, p.nr})};
    cg = {1'b0, p.dst[15:8]}  + {1'b0, div255({1'b0, p.ng})};
    cb = {1'b0, p.dst[7:0]}   + {1'b0, div255({1'b0, p.nb})};
    oa = p.a + div255(p.na);
    we_nxt  = p.we;
    cov_nxt = p.we ? p.a : 8'd0;
    if (!p.we)          pix_nxt = 32'd0;
    else if (additive_r) pix_nxt = {oa, cr[8] ? 8'hFF : cr[7:0],
                                    cg[8] ? 8'hFF : cg[7:0], cb[8] ? 8'hFF : cb[7:0]};
    else                pix_nxt = {p.a, brush_color_r};
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) valid_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) valid_r[i] <= valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ST_OUT; i++) begin
      if (en[i]) pipe_r[i] <= pipe_nxt[i];
    end
    pipe_r[ST_OUT] <= '0;
    if (en[ST_OUT]) begin
      we_r  <= we_nxt;
      cov_r <= cov_nxt;
      pix_r <= pix_nxt;
    end
  end

  assign out_valid        = valid_r[ST_OUT];
  assign out_write_enable = we_r;
  assign out_coverage     = cov_r;
  assign out_out_pixel    = pix_r;

endmodule

// ===== hw/rtl/soft_dab_pixel_shader_unit_chk.sv =====
// Port-level checker for the soft dab shader, bound to the top level.
`timescale 1ns / 1ps
`include "soft_dab_pixel_shader_unit_defines.svh"
module soft_dab_pixel_shader_unit_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_write_enable,
  input logic [7:0]  out_coverage,
  input logic [31:0] out_out_pixel
);
  // Pipeline comes out of reset empty
  `SD_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")
  // A held result stays offered
  `SD_ASSERT(a_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
  // With an empty output the pipeline must take input
  `SD_ASSERT(a_no_stall, !out_valid |-> !in_stall, "input stalled with empty output")
  // Skipped pixels carry nothing
  `SD_ASSERT(a_skip_zero, out_valid && !out_write_enable |-> out_coverage == 8'd0 && out_out_pixel == 32'd0, "skipped pixel has payload")
  // Written pixels have coverage
  `SD_ASSERT(a_we_cov, out_valid && out_write_enable |-> out_coverage != 8'd0, "write with zero coverage")
endmodule

bind soft_dab_pixel_shader_unit soft_dab_pixel_shader_unit_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_write_enable(out_write_enable),
  .out_coverage(out_coverage), .out_out_pixel(out_out_pixel)
);
